[rtl/c8ie_pkg.sv]
// Package: shared types and constants for the CHIP-8 execute block.
`timescale 1ns / 1ps
`default_nettype none
package c8ie_pkg;
	localparam logic [11:0] START_RESET = 12'h200;
	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_OVER  = 2'd1;
	localparam logic [1:0] FAULT_UNDER = 2'd2;

	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SEI  = 4'h3;
	localparam logic [3:0] GRP_SNI  = 4'h4;
	localparam logic [3:0] GRP_SER  = 4'h5;
	localparam logic [3:0] GRP_LDI  = 4'h6;
	localparam logic [3:0] GRP_ADDI = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SNR  = 4'h9;
	localparam logic [3:0] GRP_LDIX = 4'hA;
	localparam logic [3:0] GRP_JPV0 = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_MISC = 4'hF;

	localparam logic [15:0] OP_HALT = 16'h0000;
	localparam logic [15:0] OP_RET  = 16'h00EE;
	localparam logic [7:0] FX_LDDT  = 8'h07;
	localparam logic [7:0] FX_SETDT = 8'h15;
	localparam logic [7:0] FX_ADDI  = 8'h1E;
	localparam logic [7:0] FX_STORE = 8'h55;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// controller -> datapath
	typedef struct packed {
		logic        load;   // latch instruction beat
		logic        exec;   // execute latched instruction
		logic        store;  // emit one store beat for register k
		logic        clr_k;
		logic        inc_k;
		logic        cfg_we;
	} c8ie_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_store;  // latched op is FX55 and not halted
		logic k_last;    // k equals X
	} c8ie_sts_t;
endpackage
`default_nettype wire

[rtl/c8ie_if.sv]
// Interfaces: valid/ready channels for instructions, results and config.
`timescale 1ns / 1ps
`default_nettype none
interface c8ie_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] instruction;
	logic [7:0]  random_byte;
	modport source (output valid, instruction, random_byte, input ready);
	modport sink (input valid, instruction, random_byte, output ready);
endinterface

interface c8ie_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] next_address;
	logic        stopped;
	logic [1:0]  fault;
	logic        store_valid;
	logic [11:0] store_address;
	logic [7:0]  store_data;
	logic        last_of_item;
	modport source (output valid, next_address, stopped, fault, store_valid,
		store_address, store_data, last_of_item, input ready);
	modport sink (input valid, next_address, stopped, fault, store_valid,
		store_address, store_data, last_of_item, output ready);
endinterface

interface c8ie_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/c8ie_datapath.sv]
// Datapath: register file, I, PC, return stack, timer and result fields.
`timescale 1ns / 1ps
`default_nettype none
module c8ie_datapath import c8ie_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire c8ie_cmd_t   cmd,
	output c8ie_sts_t        sts,
	input  wire logic [15:0] instruction,
	input  wire logic [7:0]  random_byte,
	input  wire logic [11:0] cfg_data,
	output logic [11:0]      next_address,
	output logic             stopped,
	output logic [1:0]       fault,
	output logic             store_valid,
	output logic [11:0]      store_address,
	output logic [7:0]       store_data,
	output logic             last_of_item
);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [7:0]    v_q [16];
	logic [11:0]   i_q, pc_q;
	logic [11:0]   stk_q [STACK_DEPTH];
	logic [DW-1:0] sp_q;
	logic [7:0]    dt_q;
	logic          halt_q;
	logic [15:0]   op_q;
	logic [7:0]    rnd_q;
	logic [3:0]    k_q;

	logic [3:0]  x, y, n;
	logic [7:0]  nn, vx, vy;
	logic [11:0] nnn, pc2, pc4;
	logic [8:0]  sum;
	logic        full, empty;

	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];
	assign vx  = v_q[x];
	assign vy  = v_q[y];
	assign pc2 = pc_q + 12'd2;
	assign pc4 = pc_q + 12'd4;
	assign sum = {1'b0, vx} + {1'b0, vy};
	assign full  = (sp_q == DW'(STACK_DEPTH));
	assign empty = (sp_q == '0);

	assign sts.is_store = !halt_q && op_q[15:12] == GRP_MISC && nn == FX_STORE;
	assign sts.k_last   = (k_q == x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 16; r++) v_q[r] <= '0;
			for (int s = 0; s < STACK_DEPTH; s++) stk_q[s] <= '0;
			i_q <= '0;
			pc_q <= START_RESET;
			sp_q <= '0;
			dt_q <= '0;
			halt_q <= 1'b0;
			k_q <= '0;
			next_address  <= '0;
			stopped       <= 1'b0;
			fault         <= FAULT_NONE;
			store_valid   <= 1'b0;
			store_address <= '0;
			store_data    <= '0;
			last_of_item  <= 1'b0;
		end else begin
			if (cmd.cfg_we) pc_q <= cfg_data;
			if (cmd.clr_k) k_q <= '0;
			else if (cmd.inc_k) k_q <= k_q + 4'd1;
			if (cmd.store) begin
				next_address  <= pc2;
				stopped       <= 1'b0;
				fault         <= FAULT_NONE;
				store_valid   <= 1'b1;
				store_address <= i_q + {8'd0, k_q};
				store_data    <= v_q[k_q];
				last_of_item  <= sts.k_last;
				if (sts.k_last) pc_q <= pc2;
			end
			if (cmd.exec) begin
				logic [11:0] nx;
				logic [1:0]  f;
				nx = pc2;
				f = FAULT_NONE;
				if (halt_q) begin
					nx = pc_q;
				end else begin
					unique case (op_q[15:12])
					GRP_SYS: begin
						if (op_q == OP_HALT) begin
							halt_q <= 1'b1;
							nx = pc_q;
						end else if (op_q == OP_RET) begin
							if (empty) f = FAULT_UNDER;
							else begin
								sp_q <= sp_q - DW'(1);
								nx = stk_q[SW'(sp_q - DW'(1))];
							end
						end
					end
					GRP_JP: nx = nnn;
					GRP_CALL: begin
						if (full) f = FAULT_OVER;
						else begin
							stk_q[SW'(sp_q)] <= pc2;
							sp_q <= sp_q + DW'(1);
							nx = nnn;
						end
					end
					GRP_SEI: if (vx == nn) nx = pc4;
					GRP_SNI: if (vx != nn) nx = pc4;
					GRP_SER: if (vx == vy) nx = pc4;
					GRP_LDI: v_q[x] <= nn;
					GRP_ADDI: v_q[x] <= vx + nn;
					GRP_ALU: begin
						unique case (n)
						ALU_MOV: v_q[x] <= vy;
						ALU_OR:  v_q[x] <= vx | vy;
						ALU_AND: v_q[x] <= vx & vy;
						ALU_XOR: v_q[x] <= vx ^ vy;
						ALU_ADD: begin
							v_q[x] <= sum[7:0];
							v_q[15] <= {7'd0, sum[8]};
						end
						ALU_SUB: begin
							v_q[x] <= vx - vy;
							v_q[15] <= {7'd0, vx >= vy};
						end
						ALU_SHR: begin
							v_q[x] <= vx >> 1;
							v_q[15] <= {7'd0, vx[0]};
						end
						ALU_SBN: begin
							v_q[x] <= vy - vx;
							v_q[15] <= {7'd0, vy >= vx};
						end
						ALU_SHL: begin
							v_q[x] <= vx << 1;
							v_q[15] <= {7'd0, vx[7]};
						end
						default: ;
						endcase
					end
					GRP_SNR: if (vx != vy) nx = pc4;
					GRP_LDIX: i_q <= nnn;
					GRP_JPV0: nx = nnn + {4'd0, v_q[0]};
					GRP_RND: v_q[x] <= rnd_q & nn;
					GRP_MISC: begin
						if (nn == FX_LDDT) v_q[x] <= dt_q;
						else if (nn == FX_SETDT) dt_q <= vx;
						else if (nn == FX_ADDI) i_q <= i_q + {4'd0, vx};
					end
					default: ;
					endcase
				end
				pc_q          <= nx;
				next_address  <= nx;
				stopped       <= halt_q || (op_q == OP_HALT);
				fault         <= f;
				store_valid   <= 1'b0;
				store_address <= '0;
				store_data    <= '0;
				last_of_item  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= instruction;
			rnd_q <= random_byte;
		end
	end
endmodule
`default_nettype wire

[rtl/c8ie_ctrl.sv]
// Controller: sequences accept, execute, FX55 store walk and result beats.
`timescale 1ns / 1ps
`default_nettype none
module c8ie_ctrl import c8ie_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire c8ie_sts_t sts,
	output c8ie_cmd_t      cmd
);
	typedef enum logic [1:0] {S_IDLE, S_DEC, S_OUT, S_STORE} state_t;
	state_t state_q;
	logic   more_q;  // more store beats follow the one on the output

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load   = in_valid && in_ready;
		cmd.cfg_we = cfg_valid && cfg_ready;
		cmd.exec   = (state_q == S_DEC) && !sts.is_store;
		cmd.store  = (state_q == S_STORE);
		cmd.clr_k  = (state_q == S_DEC);
		cmd.inc_k  = (state_q == S_STORE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			more_q    <= 1'b0;
		end else begin
			unique case (state_q)
			S_IDLE: if (in_valid) state_q <= S_DEC;
			S_DEC: begin
				if (sts.is_store) state_q <= S_STORE;
				else begin
					out_valid <= 1'b1;
					more_q <= 1'b0;
					state_q <= S_OUT;
				end
			end
			S_STORE: begin
				out_valid <= 1'b1;
				more_q <= !sts.k_last;
				state_q <= S_OUT;
			end
			S_OUT: if (out_ready) begin
				out_valid <= 1'b0;
				state_q <= more_q ? S_STORE : S_IDLE;
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/chip8_instruction_execute_top.sv]
// Top level: CHIP-8 instruction execute core.
// Sequence: an instruction beat is accepted in S_IDLE, executed in S_DEC and
// its registered result beat is held in S_OUT until taken; no new instruction
// is accepted before then. FX55 gives X+1 store beats, each loaded in S_STORE
// and then held in S_OUT until taken.
// Reset (arst_n low): V, I, stack, timer, halt clear; PC to 0x200.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_execute_top import c8ie_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	c8ie_in_if.sink    instr,
	c8ie_out_if.source result,
	c8ie_cfg_if.sink   cfg
);
	c8ie_cmd_t cmd;
	c8ie_sts_t sts;

	// controller owns the handshakes; datapath owns all architectural state
	c8ie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(instr.valid), .in_ready(instr.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
		.sts(sts), .cmd(cmd)
	);

	c8ie_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.instruction(instr.instruction), .random_byte(instr.random_byte),
		.cfg_data(cfg.data),
		.next_address(result.next_address), .stopped(result.stopped),
		.fault(result.fault), .store_valid(result.store_valid),
		.store_address(result.store_address), .store_data(result.store_data),
		.last_of_item(result.last_of_item)
	);
endmodule
`default_nettype wire

[sim/chip8_instruction_execute_top_tb.sv]
// Testbench: CHIP-8 execute core checked beat by beat against an in-bench executor.
`timescale 1ns / 1ps
module chip8_instruction_execute_top_tb;
	import c8ie_pkg::*;

	// One result beat as the core reports it.
	typedef struct packed {
		logic [11:0] next_address;
		logic        stopped;
		logic [1:0]  fault;
		logic        store_valid;
		logic [11:0] store_address;
		logic [7:0]  store_data;
		logic        last_of_item;
	} outcome_t;

	// Directed stimulus row; chk set where the outcome is typed in by hand.
	typedef struct packed {
		logic [15:0] op;
		logic [7:0]  rnd;
		logic        chk;
		outcome_t    want;
	} drow_t;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE   = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	c8ie_in_if  instr();
	c8ie_out_if result();
	c8ie_cfg_if cfg();

	chip8_instruction_execute_top i_dut (
		.clk(clk), .arst_n(arst_n), .instr(instr), .result(result), .cfg(cfg)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow machine state
	logic [7:0]  vreg [16];
	logic [11:0] ireg;
	logic [11:0] pc;
	logic [11:0] call_stack [16];
	int          depth;
	logic [7:0]  dtimer;
	logic        halted;

	outcome_t pending_beats[$];
	int       fails = 0;
	int       idle_cycles = 0;
	bit       calm = 1'b0;   // no idling on either side while set

	function automatic outcome_t mk(logic [11:0] na, logic [1:0] f, logic sv,
			logic [11:0] sa, logic [7:0] sd, logic last);
		outcome_t o;
		o.next_address = na; o.stopped = halted; o.fault = f;
		o.store_valid = sv; o.store_address = sa; o.store_data = sd;
		o.last_of_item = last;
		return o;
	endfunction

	// Execute one opcode on the shadow state and queue the beats it yields.
	function automatic void execute_op(logic [15:0] op, logic [7:0] rnd);
		logic [3:0]  x, y;
		logic [7:0]  nn, vx, vy;
		logic [11:0] nnn, nxt;
		logic [1:0]  f;
		logic [8:0]  sum;
		x = op[11:8]; y = op[7:4]; nn = op[7:0]; nnn = op[11:0];
		vx = vreg[x]; vy = vreg[y];
		nxt = pc + 12'd2;
		f = FAULT_NONE;
		if (halted) begin
			pending_beats.push_back(mk(pc, FAULT_NONE, 1'b0, '0, '0, 1'b1));
			return;
		end
		case (op[15:12])
			GRP_SYS: begin
				if (op == OP_HALT) begin
					halted = 1'b1;
					nxt = pc;
				end else if (op == OP_RET) begin
					if (depth == 0) f = FAULT_UNDER;
					else begin
						depth--;
						nxt = call_stack[depth];
					end
				end
			end
			GRP_JP: nxt = nnn;
			GRP_CALL: begin
				if (depth >= 16) f = FAULT_OVER;
				else begin
					call_stack[depth] = nxt;
					depth++;
					nxt = nnn;
				end
			end
			GRP_SEI: if (vx == nn) nxt = pc + 12'd4;
			GRP_SNI: if (vx != nn) nxt = pc + 12'd4;
			GRP_SER: if (vx == vy) nxt = pc + 12'd4;
			GRP_LDI: vreg[x] = nn;
			GRP_ADDI: vreg[x] = vx + nn;
			GRP_ALU: begin
				case (op[3:0])
					ALU_MOV: vreg[x] = vy;
					ALU_OR:  vreg[x] = vx | vy;
					ALU_AND: vreg[x] = vx & vy;
					ALU_XOR: vreg[x] = vx ^ vy;
					ALU_ADD: begin
						sum = vx + vy;
						vreg[x] = sum[7:0];
						vreg[15] = {7'd0, sum[8]};
					end
					ALU_SUB: begin
						vreg[x] = vx - vy;
						vreg[15] = {7'd0, vx >= vy};
					end
					ALU_SHR: begin
						vreg[x] = vx >> 1;
						vreg[15] = {7'd0, vx[0]};
					end
					ALU_SBN: begin
						vreg[x] = vy - vx;
						vreg[15] = {7'd0, vy >= vx};
					end
					ALU_SHL: begin
						vreg[x] = vx << 1;
						vreg[15] = {7'd0, vx[7]};
					end
					default: ;
				endcase
			end
			GRP_SNR: if (vx != vy) nxt = pc + 12'd4;
			GRP_LDIX: ireg = nnn;
			GRP_JPV0: nxt = nnn + {4'd0, vreg[0]};
			GRP_RND: vreg[x] = rnd & nn;
			GRP_MISC: begin
				if (nn == FX_LDDT) vreg[x] = dtimer;
				else if (nn == FX_SETDT) dtimer = vx;
				else if (nn == FX_ADDI) ireg = ireg + {4'd0, vx};
				else if (nn == FX_STORE) begin
					pc = nxt;
					for (int k = 0; k <= x; k++)
						pending_beats.push_back(mk(nxt, FAULT_NONE, 1'b1,
							ireg + 12'(k), vreg[k], k == x));
					return;
				end
			end
			default: ;
		endcase
		pc = nxt;
		pending_beats.push_back(mk(nxt, f, 1'b0, '0, '0, 1'b1));
	endfunction

	function automatic void reset_shadow();
		for (int i = 0; i < 16; i++) begin
			vreg[i] = '0;
			call_stack[i] = '0;
		end
		ireg = '0; pc = START_RESET; depth = 0; dtimer = '0; halted = 1'b0;
	endfunction

	// Sink side: random back-pressure, every beat compared to the oldest
	// expectation field by field.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				outcome_t got, exp;
				got = '{result.next_address, result.stopped, result.fault,
					result.store_valid, result.store_address, result.store_data,
					result.last_of_item};
				if (pending_beats.size() == 0) begin
					$error("result beat with nothing expected");
					fails++;
				end else begin
					exp = pending_beats.pop_front();
					if (got.next_address !== exp.next_address) begin
						$error("next_address exp %h got %h", exp.next_address,
							got.next_address); fails++;
					end
					if (got.stopped !== exp.stopped) begin
						$error("stopped exp %b got %b", exp.stopped, got.stopped);
						fails++;
					end
					if (got.fault !== exp.fault) begin
						$error("fault exp %0d got %0d", exp.fault, got.fault);
						fails++;
					end
					if (got.store_valid !== exp.store_valid) begin
						$error("store_valid exp %b got %b", exp.store_valid,
							got.store_valid); fails++;
					end
					if (got.store_address !== exp.store_address) begin
						$error("store_address exp %h got %h", exp.store_address,
							got.store_address); fails++;
					end
					if (got.store_data !== exp.store_data) begin
						$error("store_data exp %h got %h", exp.store_data,
							got.store_data); fails++;
					end
					if (got.last_of_item !== exp.last_of_item) begin
						$error("last_of_item exp %b got %b", exp.last_of_item,
							got.last_of_item); fails++;
					end
				end
			end
			result.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
		end
	end

	// Watchdog: counts cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((instr.valid && instr.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Hand one instruction beat to the core, with a random leading gap.
	// The core is busy in S_DEC and S_OUT after it accepts a beat, so
	// dropping valid afterwards costs no throughput.
	task automatic send_op(logic [15:0] op, logic [7:0] rnd);
		while (!calm && $urandom_range(99) < 29) @(posedge clk);
		instr.valid <= 1'b1;
		instr.instruction <= op;
		instr.random_byte <= rnd;
		@(posedge clk);
		while (!instr.ready) @(posedge clk);
		execute_op(op, rnd);
		instr.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Start address write: only with the core idle.
	task automatic load_start(logic [11:0] addr);
		cfg.valid <= 1'b1;
		cfg.data <= addr;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		pc = addr;
		@(posedge clk);
	endtask

	// Random opcode: mostly well-formed groups, FX codes steered to used ones.
	function automatic logic [15:0] pick_op();
		logic [15:0] op;
		int r;
		op = 16'($urandom);
		r = $urandom_range(99);
		if (r < 4) op = OP_RET;
		else if (r < 30) op[15:12] = GRP_ALU;
		else if (r < 45) begin
			op[15:12] = GRP_MISC;
			case ($urandom_range(4))
				0: op[7:0] = FX_LDDT;
				1: op[7:0] = FX_SETDT;
				2: op[7:0] = FX_ADDI;
				3: op[7:0] = FX_STORE;
				default: ;
			endcase
		end
		else if (r < 50) op[3:0] = ($urandom_range(1)) ? ALU_SHL : op[3:0];
		if (op[15:12] == GRP_ALU && $urandom_range(3) != 0)
			op[3:0] = 4'($urandom_range(7));
		// Never halt here, otherwise the rest of the run is frozen.
		if (op == OP_HALT) op = 16'h6000;
		return op;
	endfunction

	// Directed table: expectations typed in only for obvious rows.
	drow_t dtab[] = '{
		'{16'h00EE, 8'h00, 1'b1, '{12'h202, 1'b0, FAULT_UNDER, 1'b0, 12'h0,
			8'h0, 1'b1}},
		'{16'h6AFF, 8'h00, 1'b1, '{12'h204, 1'b0, FAULT_NONE, 1'b0, 12'h0,
			8'h0, 1'b1}},
		'{16'h6B01, 8'h00, 1'b0, '0},
		'{16'h8AB4, 8'h00, 1'b0, '0},   // carry out into VF
		'{16'h8BA5, 8'h00, 1'b0, '0},   // no borrow, VF set
		'{16'h8AB7, 8'h00, 1'b0, '0},
		'{16'h8A06, 8'h00, 1'b0, '0},
		'{16'h8A0E, 8'h00, 1'b0, '0},
		'{16'h8F14, 8'h00, 1'b0, '0},   // flag wins over result in VF
		'{16'h8121, 8'h00, 1'b0, '0},
		'{16'h8232, 8'h00, 1'b0, '0},
		'{16'h8343, 8'h00, 1'b0, '0},
		'{16'h3AFF, 8'h00, 1'b0, '0},
		'{16'h4A00, 8'h00, 1'b0, '0},
		'{16'h5AB0, 8'h00, 1'b0, '0},
		'{16'h9AB0, 8'h00, 1'b0, '0},
		'{16'hCAF0, 8'hFF, 1'b0, '0},
		'{16'hAFFF, 8'h00, 1'b0, '0},
		'{16'hFA1E, 8'h00, 1'b0, '0},   // I wraps
		'{16'hFA15, 8'h00, 1'b0, '0},
		'{16'hF307, 8'h00, 1'b0, '0},
		'{16'hFF55, 8'h00, 1'b0, '0},   // all sixteen registers stored
		'{16'h2FFE, 8'h00, 1'b0, '0},
		'{16'hB123, 8'h00, 1'b0, '0},
		'{16'h1FFF, 8'h00, 1'b0, '0}
	};

	initial begin
		instr.valid = 1'b0;
		instr.instruction = '0;
		instr.random_byte = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		reset_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dtab[i]) begin
			if (dtab[i].chk) begin
				execute_op(dtab[i].op, dtab[i].rnd);
				void'(pending_beats.pop_back());
				pending_beats.push_back(dtab[i].want);
				// re-run state update was done above; only the beat replaced
				instr.valid <= 1'b1;
				instr.instruction <= dtab[i].op;
				instr.random_byte <= dtab[i].rnd;
				@(posedge clk);
				while (!instr.ready) @(posedge clk);
				instr.valid <= 1'b0;
				@(posedge clk);
			end else
				send_op(dtab[i].op, dtab[i].rnd);
		end
		// Fill the return stack, overflow it, then unwind past empty.
		for (int i = 0; i < 17; i++) send_op({GRP_CALL, 12'($urandom)}, 8'h00);
		for (int i = 0; i < 17; i++) send_op(OP_RET, 8'h00);
		drain();

		// Phase per start address, extremes included; a halt follows the last phase.
		for (int ph = 0; ph < 4; ph++) begin
			load_start(ph == 0 ? 12'h000 : ph == 1 ? 12'hFFF :
				12'($urandom));
			calm = (ph == 2);
			for (int n = 0; n < 24; n++) send_op(pick_op(), 8'($urandom));
			calm = 1'b0;
			drain();
		end
		send_op(OP_HALT, 8'h00);
		send_op(16'h1234, 8'h00);
		send_op(16'hFF55, 8'h00);
		drain();

		if (fails == 0 && pending_beats.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
